// ===== rtl/periodic_task_tick_scheduler_core_defines.svh =====
// assertion macros for the periodic task tick scheduler
// needs a clock named clk and an active-low reset named rst_n in the using module
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define PTTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ptts_pkg.sv =====
// shared types and constants for the periodic task tick scheduler
// no dependencies
package ptts_pkg;

  localparam int TASK_SLOTS_DEF = 8;

  localparam int TICK_W   = 8;
  localparam int SLOT_W   = 3;
  localparam int CNT_W    = 16;

  localparam logic [TICK_W-1:0] TICK_MS_RST = 8'd1;

  // input tdata layout
  localparam int IN_SLOT_LSB  = 0;
  localparam int IN_PER_LSB   = IN_SLOT_LSB + SLOT_W;
  localparam int IN_DLY_LSB   = IN_PER_LSB + CNT_W;
  localparam int IN_RDY_LSB   = IN_DLY_LSB + CNT_W;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 8;

  typedef enum logic {
    ACT_TICK   = 1'b0,
    ACT_CREATE = 1'b1
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } st_t;

  // per-cell control
  typedef struct packed {
    logic wr;
    logic ready_req;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/periodic_task_tick_scheduler_core.sv =====
// tick scheduler: a token walks the task slots one cell per cycle
// a create beat leaves the input ready; a tick beat holds in_tready low through the walk and the flush
// a due result is registered out in the cycle after the next due slot is walked; the last or
// none-due result is pushed from the flush state once the output can take it; output stalls stop the walk
// synchronous reset clears all slot valid flags at once and sets tick_ms to 1
// top level; depends on ptts_pkg, ptts_cell and the defines header
`include "periodic_task_tick_scheduler_core_defines.svh"

module periodic_task_tick_scheduler_core #(
  parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // task_slot[2:0], period[18:3], first_delay[34:19], ready_req[35], zero pad
  input  logic [ptts_pkg::IN_DATA_W-1:0]    in_tdata,
  // action
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // due_task[2:0], zero pad
  output logic [ptts_pkg::OUT_DATA_W-1:0]   out_tdata,
  // none_due
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [ptts_pkg::TICK_W-1:0]       cfg_wr_data
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  ptts_pkg::st_t                   state_r, state_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic                            pend_vld_r, pend_vld_nxt;
  logic [ptts_pkg::SLOT_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic [ptts_pkg::SLOT_W-1:0]     out_due_r, out_due_nxt;
  logic                            out_none_r, out_none_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [ptts_pkg::TICK_W-1:0]     tick_ms_r, tick_ms_nxt;

  logic [ptts_pkg::SLOT_W-1:0]     in_slot;
  logic [ptts_pkg::CNT_W-1:0]      in_period;
  logic [ptts_pkg::CNT_W-1:0]      in_delay;
  logic                            in_ready_req;
  logic                            in_acc;
  logic                            tick_acc;
  logic                            create_acc;
  logic                            can_push;
  logic                            stall;
  logic                            advance;
  logic                            walk_end;
  logic                            hit_any;
  logic                            push;
  logic [ptts_pkg::SLOT_W-1:0]     push_due;
  logic                            push_none;
  logic                            push_last;

  logic [TASK_SLOTS-1:0]           hit_vec;
  logic [TASK_SLOTS-1:0]           tok_vec;
  logic [TASK_SLOTS:0]             tok_chain;

  assign in_slot      = in_tdata[ptts_pkg::IN_SLOT_LSB +: ptts_pkg::SLOT_W];
  assign in_period    = in_tdata[ptts_pkg::IN_PER_LSB +: ptts_pkg::CNT_W];
  assign in_delay     = in_tdata[ptts_pkg::IN_DLY_LSB +: ptts_pkg::CNT_W];
  assign in_ready_req = in_tdata[ptts_pkg::IN_RDY_LSB];

  assign in_tready  = (state_r == ptts_pkg::ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign tick_acc   = in_acc & (in_tuser == ptts_pkg::ACT_TICK);
  assign create_acc = in_acc & (in_tuser == ptts_pkg::ACT_CREATE);

  assign hit_any  = |hit_vec;
  assign can_push = ~out_vld_r | out_tready;
  assign stall    = hit_any & pend_vld_r & ~can_push;
  assign advance  = (state_r == ptts_pkg::ST_WALK) & ~stall;
  assign walk_end = advance & (idx_r == IDX_W'(TASK_SLOTS - 1));

  // slot chain
  assign tok_chain[0] = tick_acc;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    ptts_pkg::cell_ctl_t ctl;

    assign ctl.wr        = create_acc & (int'(in_slot) == i);
    assign ctl.ready_req = in_ready_req;
    assign ctl.shift     = tick_acc | advance;
    assign tok_vec[i]    = tok_chain[i+1];

    ptts_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .period     (in_period),
      .first_delay(in_delay),
      .tick_ms    (tick_ms_r),
      .tok_in     (tok_chain[i]),
      .tok_out    (tok_chain[i+1]),
      .hit        (hit_vec[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptts_pkg::ST_IDLE:  if (tick_acc) state_nxt = ptts_pkg::ST_WALK;
      ptts_pkg::ST_WALK:  if (walk_end) state_nxt = ptts_pkg::ST_FLUSH;
      ptts_pkg::ST_FLUSH: if (can_push) state_nxt = ptts_pkg::ST_IDLE;
      default:            state_nxt = ptts_pkg::ST_IDLE;
    endcase
  end

  // result push
  always_comb begin
    push      = 1'b0;
    push_due  = pend_idx_r;
    push_none = 1'b0;
    push_last = 1'b0;
    unique case (state_r)
      ptts_pkg::ST_WALK: begin
        push = advance & hit_any & pend_vld_r;
      end
      ptts_pkg::ST_FLUSH: begin
        push      = can_push;
        push_due  = pend_vld_r ? pend_idx_r : '0;
        push_none = ~pend_vld_r;
        push_last = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_nxt      = idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    out_vld_nxt  = out_vld_r;
    out_due_nxt  = out_due_r;
    out_none_nxt = out_none_r;
    out_last_nxt = out_last_r;
    tick_ms_nxt  = cfg_wr_en ? cfg_wr_data : tick_ms_r;
    if (tick_acc) begin
      idx_nxt      = '0;
      pend_vld_nxt = 1'b0;
    end else if (advance) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (hit_any) begin
        pend_vld_nxt = 1'b1;
        pend_idx_nxt = ptts_pkg::SLOT_W'(idx_r);
      end
    end
    if (push) begin
      out_vld_nxt  = 1'b1;
      out_due_nxt  = push_due;
      out_none_nxt = push_none;
      out_last_nxt = push_last;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ptts_pkg::ST_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      tick_ms_r  <= ptts_pkg::TICK_MS_RST;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      tick_ms_r  <= tick_ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_due_r  <= out_due_nxt;
    out_none_r <= out_none_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(ptts_pkg::OUT_DATA_W - ptts_pkg::SLOT_W){1'b0}}, out_due_r};
  assign out_tuser  = out_none_r;
  assign out_tlast  = out_last_r;

  `PTTS_ASSERT_NOW(a_tok_onehot, 1'b1, $onehot0(tok_vec), "more than one walk token")
  `PTTS_ASSERT_NOW(a_idle_no_tok, state_r != ptts_pkg::ST_WALK, tok_vec == '0,
                   "token present outside walk")
  `PTTS_ASSERT_NOW(a_none_is_last, out_tvalid && out_tuser, out_tlast,
                   "none-due result not marked last")
  `PTTS_ASSERT_NEXT(a_walk_start, tick_acc, state_r == ptts_pkg::ST_WALK && tok_vec[0],
                    "tick did not start walk at slot 0")

endmodule

// ===== rtl/ptts_cell.sv =====
// one task slot of the scheduler chain: valid, ready, period and countdown
// depends on ptts_pkg
module ptts_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptts_pkg::cell_ctl_t           ctl,
  input  logic [ptts_pkg::CNT_W-1:0]    period,
  input  logic [ptts_pkg::CNT_W-1:0]    first_delay,
  input  logic [ptts_pkg::TICK_W-1:0]   tick_ms,
  input  logic                          tok_in,
  output logic                          tok_out,
  output logic                          hit
);

  logic                       valid_r, valid_nxt;
  logic                       ready_r, ready_nxt;
  logic                       tok_r, tok_nxt;
  logic [ptts_pkg::CNT_W-1:0] per_r, per_nxt;
  logic [ptts_pkg::CNT_W-1:0] cd_r, cd_nxt;
  logic [ptts_pkg::CNT_W-1:0] tick_ext;
  logic [ptts_pkg::CNT_W-1:0] reload;
  logic                       due;
  logic                       step;

  assign tick_ext = {{(ptts_pkg::CNT_W - ptts_pkg::TICK_W){1'b0}}, tick_ms};
  assign reload   = (per_r > tick_ext) ? (per_r - tick_ext) : '0;
  assign due      = valid_r & ready_r & (cd_r == '0);
  assign step     = ctl.shift & tok_r & valid_r & ready_r;
  assign hit      = tok_r & due;
  assign tok_out  = tok_r;

  always_comb begin
    valid_nxt = valid_r;
    ready_nxt = ready_r;
    per_nxt   = per_r;
    cd_nxt    = cd_r;
    tok_nxt   = ctl.shift ? tok_in : tok_r;
    if (ctl.wr) begin
      valid_nxt = 1'b1;
      ready_nxt = ctl.ready_req;
      per_nxt   = period;
      cd_nxt    = first_delay;
    end else if (step) begin
      cd_nxt = due ? reload : (cd_r - ptts_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ready_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ready_r <= ready_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    per_r <= per_nxt;
    cd_r  <= cd_nxt;
  end

endmodule

// ===== tb/testbench.sv =====
// testbench for periodic_task_tick_scheduler_core: a directed table, then random bursts per tick_ms
// setting; typed directed rows are checked against their own expected result, all other results
// against a local copy of the task table; depends on ptts_pkg and the scheduler rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = ptts_pkg::TASK_SLOTS_DEF;
  localparam int SLOT_W = ptts_pkg::SLOT_W;
  localparam int CNT_W = ptts_pkg::CNT_W;
  localparam int TICK_W = ptts_pkg::TICK_W;
  localparam int IN_DATA_W = ptts_pkg::IN_DATA_W;
  localparam int IN_RDY_LSB = ptts_pkg::IN_RDY_LSB;
  localparam int OUT_DATA_W = ptts_pkg::OUT_DATA_W;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 16;
  localparam int RAND_PER_PHASE = 90;
  localparam int PHASES = 5;

  typedef struct {
    ptts_pkg::act_t    act;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  period;
    logic [CNT_W-1:0]  delay;
    logic              ready;
  } sched_item_t;

  typedef struct {
    logic [SLOT_W-1:0] due_task;
    logic              none_due;
    logic              last;
  } due_result_t;

  typedef struct {
    sched_item_t       it;
    bit                typed;
    logic [SLOT_W-1:0] due_task;
    logic              none_due;
  } dir_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [TICK_W-1:0]     cfg_wr_data = '0;

  // local copy of the task table
  logic             tbl_valid[NSLOT];
  logic             tbl_ready[NSLOT];
  logic [CNT_W-1:0] tbl_period[NSLOT];
  logic [CNT_W-1:0] tbl_count[NSLOT];
  logic [TICK_W-1:0] cur_tick_ms;

  due_result_t walk_res[NSLOT];
  int          walk_n;
  due_result_t due_q[$];

  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_hold = 0;
  logic [7:0] rx_mask = 8'hff;

  periodic_task_tick_scheduler_core #(
    .TASK_SLOTS(NSLOT)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // applies one beat to the table and leaves the due results in walk_res
  function automatic void walk_table(sched_item_t it);
    walk_n = 0;
    if (it.act == ptts_pkg::ACT_CREATE) begin
      if (it.slot < NSLOT) begin
        tbl_period[it.slot] = it.period;
        tbl_count[it.slot] = it.delay;
        tbl_ready[it.slot] = it.ready;
        tbl_valid[it.slot] = 1'b1;
      end
      return;
    end
    for (int s = 0; s < NSLOT; s++) begin
      if (tbl_valid[s] && tbl_ready[s]) begin
        if (tbl_count[s] == '0) begin
          tbl_count[s] = (tbl_period[s] > cur_tick_ms) ? tbl_period[s] - cur_tick_ms : '0;
          walk_res[walk_n] = '{SLOT_W'(s), 1'b0, 1'b0};
          walk_n++;
        end else begin
          tbl_count[s] = tbl_count[s] - 1'b1;
        end
      end
    end
    if (walk_n == 0) begin
      walk_res[0] = '{'0, 1'b1, 1'b1};
      walk_n = 1;
    end else begin
      walk_res[walk_n-1].last = 1'b1;
    end
  endfunction

  function automatic dir_row_t dir_row(ptts_pkg::act_t a, int slot, int per, int dly, bit rdy,
                                       bit typed = 1'b0, int due = 0, bit none = 1'b0);
    dir_row_t r;
    r.it = '{a, SLOT_W'(slot), CNT_W'(per), CNT_W'(dly), rdy};
    r.typed = typed;
    r.due_task = SLOT_W'(due);
    r.none_due = none;
    return r;
  endfunction

  function automatic sched_item_t rand_item();
    sched_item_t it;
    int pick;
    it.act = ptts_pkg::ACT_TICK;
    it.slot = SLOT_W'($urandom);
    it.period = CNT_W'($urandom);
    it.delay = CNT_W'($urandom);
    it.ready = 1'($urandom);
    if ($urandom_range(0, 99) < 62) return it;
    it.act = ptts_pkg::ACT_CREATE;
    pick = $urandom_range(0, 9);
    if (pick < 7) it.period = CNT_W'($urandom_range(0, 12));
    else if (pick == 7) it.period = '1;
    pick = $urandom_range(0, 9);
    if (pick < 7) it.delay = CNT_W'($urandom_range(0, 6));
    else if (pick == 7) it.delay = '1;
    it.ready = ($urandom_range(0, 4) != 0);
    return it;
  endfunction

  task automatic send_item(sched_item_t it, bit typed, logic [SLOT_W-1:0] t_due, logic t_none);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tuser = it.act;
    in_tdata = {{(IN_DATA_W-IN_RDY_LSB-1){1'b0}}, it.ready, it.delay, it.period, it.slot};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    walk_table(it);
    if (typed) begin
      due_q.push_back('{t_due, t_none, 1'b1});
    end else begin
      for (int k = 0; k < walk_n; k++) due_q.push_back(walk_res[k]);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_tick_ms(logic [TICK_W-1:0] v);
    while (due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_tick_ms = v;
  endtask

  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_hold = $urandom_range(10, 150);
      rx_mask = 8'($urandom) | 8'h01;
    end
    rx_hold--;
    case (rx_mode)
      RX_OPEN: out_tready = 1'b1;
      RX_COIN: out_tready = 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready = ($urandom_range(0, 3) == 0);
      default: begin
        out_tready = rx_mask[0];
        rx_mask = {rx_mask[0], rx_mask[7:1]};
      end
    endcase
  end

  always @(posedge clk) begin
    due_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_q.size() == 0) begin
        errors++;
        $error("unexpected beat: due_task %0d none_due %0b last %0b",
               out_tdata[SLOT_W-1:0], out_tuser, out_tlast);
      end else begin
        exp_r = due_q.pop_front();
        if (out_tdata[SLOT_W-1:0] !== exp_r.due_task) begin
          errors++;
          $error("due_task: expected %0d, got %0d", exp_r.due_task, out_tdata[SLOT_W-1:0]);
        end
        if (out_tuser !== exp_r.none_due) begin
          errors++;
          $error("none_due: expected %0b, got %0b", exp_r.none_due, out_tuser);
        end
        if (out_tlast !== exp_r.last) begin
          errors++;
          $error("last: expected %0b, got %0b", exp_r.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t dir_tbl[$];
    logic [TICK_W-1:0] phase_ms[PHASES];

    for (int s = 0; s < NSLOT; s++) begin
      tbl_valid[s] = 1'b0;
      tbl_ready[s] = 1'b0;
      tbl_period[s] = '0;
      tbl_count[s] = '0;
    end
    cur_tick_ms = ptts_pkg::TICK_MS_RST;

    // empty table, single due slot, extremes, suspend and resume, zero period,
    // every slot due on one tick
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0, 1'b1, 0, 1'b1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 0, 5, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0, 1'b1, 0, 1'b0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0, 1'b1, 0, 1'b1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 7, 16'hffff, 16'hffff, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 3, 2, 0, 0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 5, 0, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 3, 2, 1, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 0, 1, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 1, 0, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 2, 16'hffff, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 3, 2, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 4, 3, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 5, 0, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 6, 7, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 7, 1, 0, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 7, 16'hffff, 16'hffff, 1));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_CREATE, 4, 3, 0, 0));
    dir_tbl.push_back(dir_row(ptts_pkg::ACT_TICK, 0, 0, 0, 0));

    phase_ms[0] = '0;
    phase_ms[1] = '1;
    phase_ms[2] = TICK_W'($urandom_range(2, 254));
    phase_ms[3] = ptts_pkg::TICK_MS_RST;
    phase_ms[4] = TICK_W'($urandom);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tbl[i]) begin
      send_item(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].due_task, dir_tbl[i].none_due);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_tick_ms(phase_ms[p]);
      repeat (RAND_PER_PHASE) send_item(rand_item(), 1'b0, '0, 1'b0);
    end

    while (due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ptts_pkg.sv
rtl/ptts_cell.sv
rtl/periodic_task_tick_scheduler_core.sv
tb/testbench.sv
